FILE: sv/cpfb_pkg.sv
// Shared types and constants for the clipped pixel-format blit.
// Transaction structs, action/kind codes, register indexes and defaults.
// No dependencies.
package cpfb_pkg;

	localparam int COORD_BITS_DEF       = 16;
	localparam int MAX_CHANNEL_BITS_DEF = 16;

	localparam int CFG_ADDR_W = 6;
	localparam int CFG_DATA_W = 64;

	localparam int CHAN_IN_BITS = 8;
	localparam int ROUND_BIAS   = 127;

	localparam logic [5:0] BPP_RESET = 6'd32;

	localparam logic [1:0] ACT_AREA_START = 2'd0;
	localparam logic [1:0] ACT_PIXEL      = 2'd1;
	localparam logic [1:0] ACT_AREA_END   = 2'd2;
	localparam logic [1:0] ACT_RESERVED   = 2'd3;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_DONE  = 1'b1;

	localparam logic [2:0] BYTES_TWO   = 3'd2;
	localparam logic [2:0] BYTES_THREE = 3'd3;
	localparam logic [2:0] BYTES_FOUR  = 3'd4;

	// channel_layout bit positions: len[5:0] then off[4:0] per channel
	localparam int RED_LSB   = 0;
	localparam int GREEN_LSB = 11;
	localparam int BLUE_LSB  = 22;

	typedef enum logic [2:0] {
		REG_SCREEN_WIDTH   = 3'd0,
		REG_SCREEN_HEIGHT  = 3'd1,
		REG_PAN_X          = 3'd2,
		REG_PAN_Y          = 3'd3,
		REG_LINE_PITCH     = 3'd4,
		REG_PIXEL_DEPTH    = 3'd5,
		REG_CHANNEL_LAYOUT = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [15:0] area_left;
		logic signed [15:0] area_top;
		logic signed [15:0] area_right;
		logic signed [15:0] area_bottom;
		logic               final_flush;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
	} cmd_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] byte_address;
		logic [31:0] pixel_data;
		logic [2:0]  byte_count;
		logic        present_request;
	} res_t;

endpackage

FILE: sv/clipped_pixel_format_blit.sv
// Top level of the clipped pixel-format blit: APB registers, area walk,
// clipping, address and pixel pipeline. Uses cpfb_pkg, cpfb_channel_scale.
// Result order follows command order; one result at most per command.
//
//  channel | handshake               | payload
//  cmd     | cmd_valid / cmd_ready   | cmd (cmd_t): area header, pixel, area end
//  res     | res_valid / res_ready   | res (res_t): pixel write or area done
//  apb     | psel, penable, pready   | paddr, pwrite, pwdata, prdata
//
// One command per clock unless res_ready stalls the pipeline. A result is offered once
// its command is accepted and has passed three registers (walk/clip stage, multiply
// stage, result register).
// Each stage holds only while the stage after it is full and stalled, so
// cmd_ready drops only once all three stages back up behind res_ready.
// Reset clears registers to defaults (pixel depth 32) and the area walk.
module clipped_pixel_format_blit import cpfb_pkg::*; #(
	parameter int COORD_BITS       = COORD_BITS_DEF,
	parameter int MAX_CHANNEL_BITS = MAX_CHANNEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  cmd_t                  cmd,
	output logic                  res_valid,
	input  logic                  res_ready,
	output res_t                  res
);

	localparam int CW = COORD_BITS + 2;

	// configuration
	logic [12:0] scr_w_q;
	logic [12:0] scr_h_q;
	logic [12:0] pan_x_q;
	logic [12:0] pan_y_q;
	logic [15:0] pitch_q;
	logic [5:0]  bpp_q;
	logic [32:0] layout_q;
	reg_idx_t    widx;
	reg_idx_t    ridx;

	// area walk
	logic signed [COORD_BITS-1:0] left_q;
	logic signed [COORD_BITS-1:0] top_q;
	logic signed [COORD_BITS-1:0] right_q;
	logic signed [COORD_BITS-1:0] bottom_q;
	logic signed [COORD_BITS-1:0] col_q;
	logic signed [COORD_BITS:0]   row_q;
	logic                         final_q;

	logic signed [CW-1:0] col_w, row_w, left_w, top_w, right_w, bottom_w, sw_w, sh_w;
	logic        accept;
	logic        empty_area;
	logic        wrap;
	logic        pix_step;
	logic        visible;
	logic [3:0]  bytes4;
	logic        bytes_ok;
	logic        make_res;
	logic [13:0] col_px;
	logic [13:0] row_ln;

	// pipeline
	logic        v1_q, v2_q, ov_q;
	logic        rdy1, rdy2, rdy3;
	logic        kind_s1, present_s1;
	logic [2:0]  bytes_s1;
	logic [13:0] col_px_s1, row_ln_s1;
	logic [7:0]  red_s1, green_s1, blue_s1;
	logic        kind_s2, present_s2;
	logic [2:0]  bytes_s2;
	logic [29:0] row_addr_s2;
	logic [15:0] col_off_s2;
	logic [31:0] red_sh, green_sh, blue_sh;
	logic [31:0] pixel_all;
	logic [31:0] pixel_masked;
	res_t        res_q;

	assign pready = 1'b1;
	assign widx   = reg_idx_t'(paddr[5:3]);
	assign ridx   = reg_idx_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q  <= '0;
			scr_h_q  <= '0;
			pan_x_q  <= '0;
			pan_y_q  <= '0;
			pitch_q  <= '0;
			bpp_q    <= BPP_RESET;
			layout_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (widx)
				REG_SCREEN_WIDTH:   scr_w_q  <= pwdata[12:0];
				REG_SCREEN_HEIGHT:  scr_h_q  <= pwdata[12:0];
				REG_PAN_X:          pan_x_q  <= pwdata[12:0];
				REG_PAN_Y:          pan_y_q  <= pwdata[12:0];
				REG_LINE_PITCH:     pitch_q  <= pwdata[15:0];
				REG_PIXEL_DEPTH:    bpp_q    <= pwdata[5:0];
				REG_CHANNEL_LAYOUT: layout_q <= pwdata[32:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_SCREEN_WIDTH:   prdata = CFG_DATA_W'(scr_w_q);
			REG_SCREEN_HEIGHT:  prdata = CFG_DATA_W'(scr_h_q);
			REG_PAN_X:          prdata = CFG_DATA_W'(pan_x_q);
			REG_PAN_Y:          prdata = CFG_DATA_W'(pan_y_q);
			REG_LINE_PITCH:     prdata = CFG_DATA_W'(pitch_q);
			REG_PIXEL_DEPTH:    prdata = CFG_DATA_W'(bpp_q);
			REG_CHANNEL_LAYOUT: prdata = CFG_DATA_W'(layout_q);
			default:            prdata = '0;
		endcase
	end

	// stage readiness, back to front
	assign rdy3      = !ov_q || res_ready;
	assign rdy2      = !v2_q || rdy3;
	assign rdy1      = !v1_q || rdy2;
	assign cmd_ready = rdy1;
	assign accept    = cmd_valid && rdy1;

	always_comb begin
		col_w    = CW'(col_q);
		row_w    = CW'(row_q);
		left_w   = CW'(left_q);
		top_w    = CW'(top_q);
		right_w  = CW'(right_q);
		bottom_w = CW'(bottom_q);
		sw_w     = $signed(CW'(scr_w_q));
		sh_w     = $signed(CW'(scr_h_q));

		empty_area = (left_w > right_w) || (top_w > bottom_w) || (row_w > bottom_w);
		wrap       = col_w >= right_w;
		pix_step   = accept && (cmd.action == ACT_PIXEL) && !empty_area;
		visible    = (col_w >= 0) && (row_w >= 0) && (col_w < sw_w) && (row_w < sh_w);
		bytes4     = 4'((7'(bpp_q) + 7'd7) >> 3);
		bytes_ok   = (bytes4 >= 4'(BYTES_TWO)) && (bytes4 <= 4'(BYTES_FOUR));
		make_res   = (pix_step && visible && bytes_ok) ||
			(accept && (cmd.action == ACT_AREA_END));
		col_px     = 14'($unsigned(col_w)) + 14'(pan_x_q);
		row_ln     = 14'($unsigned(row_w)) + 14'(pan_y_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			top_q    <= '0;
			right_q  <= '0;
			bottom_q <= '0;
			col_q    <= '0;
			row_q    <= '0;
			final_q  <= 1'b0;
		end else if (accept && (cmd.action == ACT_AREA_START)) begin
			left_q   <= $signed(cmd.area_left[COORD_BITS-1:0]);
			top_q    <= $signed(cmd.area_top[COORD_BITS-1:0]);
			right_q  <= $signed(cmd.area_right[COORD_BITS-1:0]);
			bottom_q <= $signed(cmd.area_bottom[COORD_BITS-1:0]);
			col_q    <= $signed(cmd.area_left[COORD_BITS-1:0]);
			row_q    <= (COORD_BITS + 1)'($signed(cmd.area_top[COORD_BITS-1:0]));
			final_q  <= cmd.final_flush;
		end else if (pix_step) begin
			if (wrap) begin
				col_q <= left_q;
				row_q <= row_q + (COORD_BITS + 1)'(1);
			end else begin
				col_q <= col_q + COORD_BITS'(1);
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (rdy1) v1_q <= make_res;
			if (rdy2) v2_q <= v1_q;
			if (rdy3) ov_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1    <= (cmd.action == ACT_AREA_END) ? KIND_DONE : KIND_WRITE;
			present_s1 <= final_q;
			bytes_s1   <= bytes4[2:0];
			col_px_s1  <= col_px;
			row_ln_s1  <= row_ln;
			red_s1     <= cmd.red;
			green_s1   <= cmd.green;
			blue_s1    <= cmd.blue;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v1_q) begin
			kind_s2     <= kind_s1;
			present_s2  <= present_s1;
			bytes_s2    <= bytes_s1;
			row_addr_s2 <= 30'(row_ln_s1) * 30'(pitch_q);
			col_off_s2  <= 16'(col_px_s1) * 16'(bytes_s1);
		end
	end

	cpfb_channel_scale #(.MAX_CHANNEL_BITS(MAX_CHANNEL_BITS)) u_red (
		.clk     (clk),
		.en      (rdy2 && v1_q),
		.value   (red_s1),
		.len     (layout_q[RED_LSB +: 6]),
		.off     (layout_q[RED_LSB + 6 +: 5]),
		.shifted (red_sh)
	);

	cpfb_channel_scale #(.MAX_CHANNEL_BITS(MAX_CHANNEL_BITS)) u_green (
		.clk     (clk),
		.en      (rdy2 && v1_q),
		.value   (green_s1),
		.len     (layout_q[GREEN_LSB +: 6]),
		.off     (layout_q[GREEN_LSB + 6 +: 5]),
		.shifted (green_sh)
	);

	cpfb_channel_scale #(.MAX_CHANNEL_BITS(MAX_CHANNEL_BITS)) u_blue (
		.clk     (clk),
		.en      (rdy2 && v1_q),
		.value   (blue_s1),
		.len     (layout_q[BLUE_LSB +: 6]),
		.off     (layout_q[BLUE_LSB + 6 +: 5]),
		.shifted (blue_sh)
	);

	always_comb begin
		pixel_all = red_sh | green_sh | blue_sh;
		unique case (bytes_s2)
			BYTES_TWO:   pixel_masked = {16'd0, pixel_all[15:0]};
			BYTES_THREE: pixel_masked = {8'd0, pixel_all[23:0]};
			default:     pixel_masked = pixel_all;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v2_q) begin
			res_q.kind <= kind_s2;
			if (kind_s2 == KIND_DONE) begin
				res_q.byte_address    <= '0;
				res_q.pixel_data      <= '0;
				res_q.byte_count      <= '0;
				res_q.present_request <= present_s2;
			end else begin
				res_q.byte_address    <= 32'(row_addr_s2) + 32'(col_off_s2);
				res_q.pixel_data      <= pixel_masked;
				res_q.byte_count      <= bytes_s2;
				res_q.present_request <= 1'b0;
			end
		end
	end

	assign res_valid = ov_q;
	assign res       = res_q;

endmodule

FILE: sv/cpfb_channel_scale.sv
// One color channel: scale 8 bits to the configured length with rounding
// and shift to its offset. Two halves around one register; uses cpfb_pkg.
// Divide by 255 is a truncated 1/256 series plus one small correction.
module cpfb_channel_scale import cpfb_pkg::*; #(
	parameter int MAX_CHANNEL_BITS = MAX_CHANNEL_BITS_DEF
) (
	input  logic        clk,
	input  logic        en,
	input  logic [7:0]  value,
	input  logic [5:0]  len,
	input  logic [4:0]  off,
	output logic [31:0] shifted
);

	localparam int NW    = MAX_CHANNEL_BITS + CHAN_IN_BITS;
	localparam int TERMS = (NW + CHAN_IN_BITS - 1) / CHAN_IN_BITS;

	logic [5:0]                  len_c;
	logic [NW-1:0]               num;
	logic [NW-1:0]               q0;
	logic [NW-1:0]               num_s2;
	logic [NW-1:0]               q0_s2;
	logic [NW-1:0]               prod;
	logic [NW-1:0]               rem;
	logic [10:0]                 rem_lo;
	logic [11:0]                 corr;
	logic [NW-1:0]               quot;
	logic [MAX_CHANNEL_BITS-1:0] scaled;
	logic [31:0]                 scaled_w;

	always_comb begin
		len_c = (len > 6'(MAX_CHANNEL_BITS)) ? 6'(MAX_CHANNEL_BITS) : len;
		// v*(2^len-1) + 127
		num = (NW'(value) << len_c) - NW'(value) + NW'(ROUND_BIAS);
		q0 = '0;
		for (int i = 1; i <= TERMS; i++) begin
			q0 = q0 + (num >> (CHAN_IN_BITS * i));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2 <= num;
			q0_s2  <= q0;
		end
	end

	// estimate is low by at most TERMS, so the remainder stays small
	always_comb begin
		prod     = (q0_s2 << CHAN_IN_BITS) - q0_s2;
		rem      = num_s2 - prod;
		rem_lo   = rem[10:0];
		corr     = (12'(rem_lo) + 12'd1 + 12'(rem_lo >> CHAN_IN_BITS)) >> CHAN_IN_BITS;
		quot     = q0_s2 + NW'(corr);
		scaled   = quot[MAX_CHANNEL_BITS-1:0];
		scaled_w = 32'(scaled);
		shifted  = scaled_w << off;
	end

endmodule

FILE: tb/clipped_pixel_format_blit_tb.sv
// Self-checking bench for clipped_pixel_format_blit: APB setup, area/pixel stream,
// built-in blit predictor and in-order result check. Uses cpfb_pkg and the
// clipped_pixel_format_blit RTL, which in turn uses cpfb_channel_scale; no other files.
module clipped_pixel_format_blit_tb;
	import cpfb_pkg::*;

	localparam int STALL_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_ITEMS  = 130;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  psel      = 1'b0;
	logic                  penable   = 1'b0;
	logic                  pwrite    = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr     = '0;
	logic [CFG_DATA_W-1:0] pwdata    = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  cmd_valid = 1'b0;
	logic                  cmd_ready;
	cmd_t                  cmd       = '0;
	logic                  res_valid;
	logic                  res_ready = 1'b0;
	res_t                  res;

	clipped_pixel_format_blit u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	always #6 clk = ~clk;

	// register copies
	logic [12:0] cfg_width  = '0;
	logic [12:0] cfg_height = '0;
	logic [12:0] cfg_pan_x  = '0;
	logic [12:0] cfg_pan_y  = '0;
	logic [15:0] cfg_pitch  = '0;
	logic [5:0]  cfg_bpp    = BPP_RESET;
	logic [32:0] cfg_layout = '0;

	// area walk state
	int area_l = 0, area_t = 0, area_r = 0, area_b = 0;
	int cur_col = 0, cur_row = 0;
	logic flush_mark = 1'b0;

	cmd_t pending_cmds[$];
	res_t blit_results_due[$];
	int   mismatches = 0;
	int   items_sent = 0;
	int   send_idle = 0, recv_stall = 0;
	bit   hold_req = 1'b0;
	bit   cmd_taken = 1'b0;
	int   quiet_cycles = 0;

	function automatic logic [31:0] scale_chan(logic [7:0] v, logic [10:0] fmt);
		int len;
		longint unsigned peak, scaled;
		len = int'(fmt[5:0]);
		if (len > MAX_CHANNEL_BITS_DEF)
			len = MAX_CHANNEL_BITS_DEF;
		if (len == 0)
			return '0;
		peak = (64'd1 << len) - 64'd1;
		scaled = (64'(v) * peak + 64'(ROUND_BIAS)) / 64'd255;
		return 32'(scaled << fmt[10:6]);
	endfunction

	function automatic bit predict_blit(input cmd_t c, output res_t r);
		int col, row, nbytes;
		logic [31:0] pix;
		r = '0;
		unique case (c.action)
		ACT_AREA_START: begin
			area_l = int'($signed(c.area_left));
			area_t = int'($signed(c.area_top));
			area_r = int'($signed(c.area_right));
			area_b = int'($signed(c.area_bottom));
			flush_mark = c.final_flush;
			cur_col = area_l;
			cur_row = area_t;
			return 1'b0;
		end
		ACT_AREA_END: begin
			r.kind = KIND_DONE;
			r.present_request = flush_mark;
			return 1'b1;
		end
		ACT_PIXEL: ;
		default: return 1'b0;
		endcase
		if (area_l > area_r || area_t > area_b || cur_row > area_b)
			return 1'b0;
		col = cur_col;
		row = cur_row;
		if (cur_col >= area_r) begin
			cur_col = area_l;
			cur_row = cur_row + 1;
		end else begin
			cur_col = cur_col + 1;
		end
		nbytes = (int'(cfg_bpp) + 7) / 8;
		if (col < 0 || row < 0 || col >= int'(cfg_width) || row >= int'(cfg_height))
			return 1'b0;
		if (nbytes < 2 || nbytes > 4)
			return 1'b0;
		pix = scale_chan(c.red, cfg_layout[RED_LSB +: 11]) |
			scale_chan(c.green, cfg_layout[GREEN_LSB +: 11]) |
			scale_chan(c.blue, cfg_layout[BLUE_LSB +: 11]);
		if (nbytes == 2)
			pix[31:16] = '0;
		else if (nbytes == 3)
			pix[31:24] = '0;
		r.kind = KIND_WRITE;
		r.byte_address = (32'(row) + 32'(cfg_pan_y)) * 32'(cfg_pitch) +
			(32'(col) + 32'(cfg_pan_x)) * 32'(nbytes);
		r.pixel_data = pix;
		r.byte_count = 3'(nbytes);
		return 1'b1;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
		if (want !== seen) begin
			$display("%0t: %s expected %h got %h", $time, name, want, seen);
			mismatches++;
		end
	endtask

	// accept, predict, compare
	always @(posedge clk) begin : monitor
		res_t due, got;
		cmd_taken <= cmd_valid && cmd_ready;
		if (arst_n && cmd_valid && cmd_ready) begin
			if (predict_blit(cmd, due))
				blit_results_due.push_back(due);
		end
		if (arst_n && res_valid && res_ready) begin
			got = res;
			if (blit_results_due.size() == 0) begin
				$display("%0t: unexpected transaction expected none got %p", $time, got);
				mismatches++;
			end else begin
				due = blit_results_due.pop_front();
				check_field("kind", 32'(due.kind), 32'(got.kind));
				check_field("byte_address", due.byte_address, got.byte_address);
				check_field("pixel_data", due.pixel_data, got.pixel_data);
				check_field("byte_count", 32'(due.byte_count), 32'(got.byte_count));
				check_field("present_request", 32'(due.present_request),
					32'(got.present_request));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && cmd_ready) || (res_valid && res_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!cmd_valid || cmd_taken)) begin
			if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle) begin
				cmd <= pending_cmds.pop_front();
				cmd_valid <= 1'b1;
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : receiver
		int hold_left;
		bit hold_done;
		if (hold_req && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	task automatic cfg_write(reg_idx_t idx, logic [63:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_ADDR_W'(int'(idx) * 8);
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		unique case (idx)
		REG_SCREEN_WIDTH:   cfg_width = val[12:0];
		REG_SCREEN_HEIGHT:  cfg_height = val[12:0];
		REG_PAN_X:          cfg_pan_x = val[12:0];
		REG_PAN_Y:          cfg_pan_y = val[12:0];
		REG_LINE_PITCH:     cfg_pitch = val[15:0];
		REG_PIXEL_DEPTH:    cfg_bpp = val[5:0];
		REG_CHANNEL_LAYOUT: cfg_layout = val[32:0];
		default: ;
		endcase
	endtask

	task automatic set_config(int w, int h, int px, int py, int pitch, int bpp,
			logic [32:0] layout);
		cfg_write(REG_SCREEN_WIDTH, 64'(w));
		cfg_write(REG_SCREEN_HEIGHT, 64'(h));
		cfg_write(REG_PAN_X, 64'(px));
		cfg_write(REG_PAN_Y, 64'(py));
		cfg_write(REG_LINE_PITCH, 64'(pitch));
		cfg_write(REG_PIXEL_DEPTH, 64'(bpp));
		cfg_write(REG_CHANNEL_LAYOUT, 64'(layout));
	endtask

	function automatic logic [32:0] pack_layout(int rl, int ro, int gl, int go, int bl, int bo);
		logic [32:0] v;
		v = '0;
		v[RED_LSB +: 11] = {5'(ro), 6'(rl)};
		v[GREEN_LSB +: 11] = {5'(go), 6'(gl)};
		v[BLUE_LSB +: 11] = {5'(bo), 6'(bl)};
		return v;
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		c = cmd_t'({$urandom, $urandom, $urandom, $urandom});
		return c;
	endfunction

	task automatic push_cmd(cmd_t c);
		pending_cmds.push_back(c);
		if (c.action inside {ACT_AREA_START, ACT_PIXEL, ACT_AREA_END})
			items_sent++;
	endtask

	task automatic push_start(int l, int t, int r, int b, logic fin);
		cmd_t c;
		c = rand_cmd();
		c.action = ACT_AREA_START;
		c.area_left = 16'(l);
		c.area_top = 16'(t);
		c.area_right = 16'(r);
		c.area_bottom = 16'(b);
		c.final_flush = fin;
		push_cmd(c);
	endtask

	task automatic push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		cmd_t c;
		c = rand_cmd();
		c.action = ACT_PIXEL;
		c.red = r;
		c.green = g;
		c.blue = b;
		push_cmd(c);
	endtask

	task automatic push_end();
		cmd_t c;
		c = rand_cmd();
		c.action = ACT_AREA_END;
		push_cmd(c);
	endtask

	task automatic push_rand_pixels(int count);
		repeat (count)
			push_pixel(8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// sampled at the rising edge, where the driver and monitor state is settled
	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_cmds.size() != 0 || cmd_valid || blit_results_due.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin : stimulus
		int ph, roll, aw, ah, l, t, npix;
		cmd_t c;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (ph = 0; ph < 7; ph++) begin
			unique case (ph)
			0: set_config(100, 50, 3, 2, 400, 32, pack_layout(8, 16, 8, 8, 8, 0));
			1: set_config(64, 16, 0, 0, 128, 16, pack_layout(5, 11, 6, 5, 5, 0));
			2: set_config(4096, 4096, 8191, 8191, 65535, 24, 33'({$urandom, $urandom}));
			3: set_config(20, 10, 1, 1, 80, 63, 33'({$urandom, $urandom}));
			4: set_config(0, 0, 0, 0, 0, 17, pack_layout(0, 0, 1, 0, 16, 16));
			5: set_config(33, 21, $urandom_range(8191), $urandom_range(8191),
				$urandom_range(65535), 9, pack_layout(63, 31, 17, 0, 16, 31));
			default: set_config($urandom_range(1, 200), $urandom_range(1, 100),
				$urandom_range(8191), $urandom_range(8191), $urandom_range(65535),
				$urandom_range(63), 33'({$urandom, $urandom}));
			endcase
			unique case (ph % 4)
			0: begin send_idle = 0;  recv_stall = 0;  end
			1: begin send_idle = 60; recv_stall = 0;  end
			2: begin send_idle = 0;  recv_stall = 60; end
			default: begin send_idle = 11; recv_stall = 11; end
			endcase

			if (ph == 0) begin
				// straddles the top-left corner, then surplus pixels
				push_start(-2, -1, 1, 0, 1'b1);
				push_pixel(8'd0, 8'd0, 8'd0);
				push_pixel(8'd255, 8'd255, 8'd255);
				push_pixel(8'd255, 8'd0, 8'd0);
				push_pixel(8'd0, 8'd255, 8'd0);
				push_pixel(8'd0, 8'd0, 8'd255);
				push_pixel(8'd128, 8'd127, 8'd1);
				push_pixel(8'd254, 8'd1, 8'd128);
				push_pixel(8'd7, 8'd200, 8'd99);
				push_rand_pixels(2);
				push_end();
				// empty area
				push_start(5, 5, 2, 9, 1'b0);
				push_rand_pixels(1);
				push_end();
				c = rand_cmd();
				c.action = ACT_RESERVED;
				push_cmd(c);
				// right and bottom screen edge
				push_start(98, 49, 101, 49, 1'b1);
				push_rand_pixels(4);
				push_end();
				push_start(32767, -32768, -32768, 32767, 1'b0);
				push_end();
			end
			if (ph % 4 == 2)
				hold_req = 1'b1;

			while (items_sent < (ph + 1) * PHASE_ITEMS + 24) begin
				roll = $urandom_range(99);
				if (roll < 80) begin
					aw = $urandom_range(1, 6);
					ah = $urandom_range(1, 3);
					l = int'($urandom_range(0, int'(cfg_width) + 8)) - 6;
					t = int'($urandom_range(0, int'(cfg_height) + 4)) - 3;
					npix = aw * ah;
					if ($urandom_range(99) < 15)
						npix = npix + $urandom_range(1, 3);
					else if ($urandom_range(99) < 10)
						npix = $urandom_range(0, npix);
					push_start(l, t, l + aw - 1, t + ah - 1, 1'($urandom));
					push_rand_pixels(npix);
					push_end();
				end else if (roll < 92) begin
					push_cmd(rand_cmd());
				end else if (roll < 96) begin
					push_start($urandom_range(0, 10), $urandom_range(0, 10),
						$urandom_range(0, 20), $urandom_range(0, 20), 1'($urandom));
					push_rand_pixels($urandom_range(0, 5));
				end else begin
					push_end();
				end
			end
			wait_drained();
		end

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
